>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define HPM_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds across reset.
`define HPM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> rtl/core/hpm_pkg.sv
// ---------------------------------------------------------------------------
// hpm_pkg
// Types, constants and register indexes of the homography point mapper.
// ---------------------------------------------------------------------------
package hpm_pkg;

    localparam int COEF_N     = 8;
    localparam int COEF_W     = 32;
    localparam int COEF_IDX_W = 3;
    localparam int CFG_ADDR_W = 4;
    localparam int COORD_W    = 16;
    localparam int PROD_W     = COEF_W + COORD_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int MAG_W      = PROD_W;
    // quotient is taken with one extra fraction bit for rounding
    localparam int QB         = 17;
    localparam int DIV_STEPS  = QB;

    localparam logic [COORD_W-1:0] INVALID_COORD = 16'hFFF0;
    localparam logic [COORD_W-1:0] Q_POS_MAX     = 16'h7FFF;
    localparam logic [COORD_W-1:0] Q_NEG_MIN     = 16'h8000;
    localparam logic [QB-1:0]      Q_POS_LIM     = 17'd32767;
    localparam logic [QB-1:0]      Q_NEG_LIM     = 17'd32768;
    localparam logic [SUM_W-1:0]   ONE_Q32       = 49'h1_0000_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COEF_A = 4'd0,
        REG_COEF_B = 4'd1,
        REG_COEF_C = 4'd2,
        REG_COEF_D = 4'd3,
        REG_COEF_E = 4'd4,
        REG_COEF_F = 4'd5,
        REG_COEF_G = 4'd6,
        REG_COEF_H = 4'd7
    } hpm_reg_t;

    typedef logic [COEF_N-1:0][COEF_W-1:0] hpm_coef_t;

    localparam hpm_coef_t COEF_RESET = {32'd0, 32'd0, 32'd0, 32'd65536,
                                        32'd0, 32'd0, 32'd0, 32'd65536};

    typedef struct packed {
        logic signed [COORD_W-1:0] src_x;
        logic signed [COORD_W-1:0] src_y;
    } hpm_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] dst_x;
        logic signed [COORD_W-1:0] dst_y;
        logic                      point_valid;
    } hpm_out_t;

    // divider pipeline payload, one lane for x and one for y
    typedef struct packed {
        logic [MAG_W-1:0] rem_x;
        logic [MAG_W-1:0] rem_y;
        logic [MAG_W-1:0] den;
        logic [QB-1:0]    quo_x;
        logic [QB-1:0]    quo_y;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic             zero;
    } hpm_div_t;

endpackage

>>> rtl/core/homography_point_mapper_core.sv
// Pipeline: 4 front-end stages, 17 division steps, 1 output stage between input
// transfer and output valid. Throughput: one point per clock unless the output stalls.
// The whole pipeline advances together; it holds only while a valid output is stalled.
// Reset: coefficients return to identity, all valid bits clear, no clearing pass.
// ---------------------------------------------------------------------------
// homography_point_mapper_core
// Pipelined perspective transform of one Q12.4 point through a 3x3 matrix.
// ---------------------------------------------------------------------------
module homography_point_mapper_core
    import hpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COEF_W-1:0]     cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  hpm_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output hpm_out_t              out_data
);

    hpm_coef_t coef_reg;
    logic      en;
    logic      mac_valid;
    hpm_div_t  mac_data;
    logic      step_valid [DIV_STEPS+1];
    hpm_div_t  step_data  [DIV_STEPS+1];

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (cfg_we && (cfg_addr <= REG_COEF_H))
        begin
            coef_reg[cfg_addr[COEF_IDX_W-1:0]] <= cfg_wdata;
        end
    end

    // pipeline advances unless a finished result is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    hpm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .coef      (coef_reg),
        .out_valid (mac_valid),
        .out_data  (mac_data)
    );

    assign step_valid[0] = mac_valid;
    assign step_data[0]  = mac_data;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        hpm_div_stage u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (step_valid[i]),
            .in_data   (step_data[i]),
            .out_valid (step_valid[i+1]),
            .out_data  (step_data[i+1])
        );
    end

    hpm_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (step_valid[DIV_STEPS]),
        .in_data   (step_data[DIV_STEPS]),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

>>> rtl/core/hpm_mac.sv
// ---------------------------------------------------------------------------
// hpm_mac
// Front end: products, affine sums, magnitudes and divider setup, 4 stages.
// ---------------------------------------------------------------------------
module hpm_mac
    import hpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  hpm_in_t   in_data,
    input  hpm_coef_t coef,
    output logic      out_valid,
    output hpm_div_t  out_data
);

    logic [3:0] valid_reg;

    logic signed [PROD_W-1:0] pa_reg, pb_reg, pd_reg, pe_reg, pg_reg, ph_reg;
    logic signed [COEF_W-1:0] c_reg, f_reg;
    logic signed [SUM_W-1:0]  u_reg, v_reg, s_reg;
    logic signed [SUM_W-1:0]  u_next, v_next, s_next;
    logic [MAG_W-1:0]         mu_reg, mv_reg, ms_reg;
    logic                     nu_reg, nv_reg, ns_reg, zero_reg;
    logic signed [SUM_W-1:0]  mu_next, mv_next, ms_next;
    hpm_div_t                 div_reg, div_next;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // stage 1: six signed 32x16 products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= PROD_W'($signed(coef[REG_COEF_A]) * in_data.src_x);
            pb_reg <= PROD_W'($signed(coef[REG_COEF_B]) * in_data.src_y);
            pd_reg <= PROD_W'($signed(coef[REG_COEF_D]) * in_data.src_x);
            pe_reg <= PROD_W'($signed(coef[REG_COEF_E]) * in_data.src_y);
            pg_reg <= PROD_W'($signed(coef[REG_COEF_G]) * in_data.src_x);
            ph_reg <= PROD_W'($signed(coef[REG_COEF_H]) * in_data.src_y);
            c_reg  <= $signed(coef[REG_COEF_C]);
            f_reg  <= $signed(coef[REG_COEF_F]);
        end
    end

    // stage 2: affine sums, translation scaled by 16 (sign kept)
    always_comb
    begin
        u_next = SUM_W'(pa_reg) + SUM_W'(pb_reg) + SUM_W'($signed({c_reg, 4'b0000}));
        v_next = SUM_W'(pd_reg) + SUM_W'(pe_reg) + SUM_W'($signed({f_reg, 4'b0000}));
        s_next = SUM_W'(pg_reg) + SUM_W'(ph_reg) + $signed(ONE_Q32);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg <= u_next;
            v_reg <= v_next;
            s_reg <= s_next;
        end
    end

    // stage 3: magnitudes and signs
    always_comb
    begin
        mu_next = u_reg[SUM_W-1] ? -u_reg : u_reg;
        mv_next = v_reg[SUM_W-1] ? -v_reg : v_reg;
        ms_next = s_reg[SUM_W-1] ? -s_reg : s_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mu_reg   <= mu_next[MAG_W-1:0];
            mv_reg   <= mv_next[MAG_W-1:0];
            ms_reg   <= ms_next[MAG_W-1:0];
            nu_reg   <= u_reg[SUM_W-1];
            nv_reg   <= v_reg[SUM_W-1];
            ns_reg   <= s_reg[SUM_W-1];
            zero_reg <= (s_reg == '0);
        end
    end

    // stage 4: overflow check, the integer quotient must stay below 1
    always_comb
    begin
        div_next.rem_x = mu_reg;
        div_next.rem_y = mv_reg;
        div_next.den   = ms_reg;
        div_next.quo_x = '0;
        div_next.quo_y = '0;
        div_next.neg_x = nu_reg ^ ns_reg;
        div_next.neg_y = nv_reg ^ ns_reg;
        div_next.ovf_x = (mu_reg >= ms_reg);
        div_next.ovf_y = (mv_reg >= ms_reg);
        div_next.zero  = zero_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = div_reg;

endmodule

>>> rtl/core/hpm_div_stage.sv
// ---------------------------------------------------------------------------
// hpm_div_stage
// One restoring division step for both lanes, registered.
// ---------------------------------------------------------------------------
module hpm_div_stage
    import hpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  hpm_div_t in_data,
    output logic     out_valid,
    output hpm_div_t out_data
);

    logic     valid_reg;
    hpm_div_t data_reg, data_next;
    logic [MAG_W:0] rx2, ry2, den_ext;
    logic           gx, gy;
    logic [MAG_W:0] dx, dy;

    // shift remainder, subtract divisor when it fits
    always_comb
    begin
        rx2     = {in_data.rem_x, 1'b0};
        ry2     = {in_data.rem_y, 1'b0};
        den_ext = {1'b0, in_data.den};
        gx      = (rx2 >= den_ext);
        gy      = (ry2 >= den_ext);
        dx      = rx2 - den_ext;
        dy      = ry2 - den_ext;

        data_next       = in_data;
        data_next.rem_x = gx ? dx[MAG_W-1:0] : rx2[MAG_W-1:0];
        data_next.rem_y = gy ? dy[MAG_W-1:0] : ry2[MAG_W-1:0];
        data_next.quo_x = {in_data.quo_x[QB-2:0], gx};
        data_next.quo_y = {in_data.quo_y[QB-2:0], gy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/hpm_round.sv
// ---------------------------------------------------------------------------
// hpm_round
// Rounding, sign, saturation and zero-denominator handling; output register.
// ---------------------------------------------------------------------------
module hpm_round
    import hpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  hpm_div_t in_data,
    output logic     out_valid,
    output hpm_out_t out_data
);

    logic     valid_reg;
    hpm_out_t data_reg, data_next;

    function automatic logic [COORD_W-1:0] finish(input logic [QB-1:0] t,
                                                  input logic neg,
                                                  input logic ovf);
        logic [QB:0]   sum;
        logic [QB-1:0] q;
        logic [COORD_W-1:0] res;
        begin
            // t carries one extra fraction bit: add half and drop it
            sum = {1'b0, t} + (QB+1)'(1);
            q   = sum[QB:1];
            if (ovf)
            begin
                res = neg ? Q_NEG_MIN : Q_POS_MAX;
            end
            else if (q == '0)
            begin
                res = '0;
            end
            else if (neg)
            begin
                res = (q >= Q_NEG_LIM) ? Q_NEG_MIN : COORD_W'(-q);
            end
            else
            begin
                res = (q > Q_POS_LIM) ? Q_POS_MAX : q[COORD_W-1:0];
            end
            return res;
        end
    endfunction

    always_comb
    begin
        if (in_data.zero)
        begin
            data_next.dst_x       = INVALID_COORD;
            data_next.dst_y       = INVALID_COORD;
            data_next.point_valid = 1'b0;
        end
        else
        begin
            data_next.dst_x       = finish(in_data.quo_x, in_data.neg_x, in_data.ovf_x);
            data_next.dst_y       = finish(in_data.quo_y, in_data.neg_y, in_data.ovf_y);
            data_next.point_valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/hpm_checker.sv
// ---------------------------------------------------------------------------
// hpm_checker
// Port-level checks of the point mapper, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hpm_checker
    import hpm_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input hpm_in_t  in_data,
    input logic     out_valid,
    input logic     out_stall,
    input hpm_out_t out_data
);

    // held result stays put until its transfer
    `HPM_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))

    // stalled input point stays put until its transfer
    `HPM_ASSERT_RST(a_in_hold, clk, rst_n, in_valid && in_stall |=> in_valid && $stable(in_data))

    // input is only held back by a stalled output
    `HPM_ASSERT_RST(a_stall_src, clk, rst_n, in_stall |-> out_valid && out_stall)

    // a point with zero denominator reads as minus one on both axes
    `HPM_ASSERT_RST(a_invalid_pt, clk, rst_n, out_valid && !out_data.point_valid |-> out_data.dst_x == INVALID_COORD && out_data.dst_y == INVALID_COORD)

    // nothing leaves the pipe right after reset
    `HPM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind homography_point_mapper_core hpm_checker u_hpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> tb/homography_point_mapper_core_tb.sv
// ---------------------------------------------------------------------------
// homography_point_mapper_core_tb
// Self-checking bench for the perspective point mapper. Coefficient sets
// (identity, extremes, singular rows, random) are loaded while the pipeline
// is empty. Points are sent with random idle bursts on both channels. Every
// output transfer is checked against a bit-exact fixed-point prediction.
// ---------------------------------------------------------------------------
module homography_point_mapper_core_tb;
    import hpm_pkg::*;

    localparam int DRAIN_CYCLES = 30;    // a margin beyond the pipeline latency
    localparam int STALL_LIMIT  = 5000;  // cycles with no transfer at all

    // Scoreboard: keeps its own copy of the coefficients, predicts each
    // mapped point and matches output transfers in order
    class point_scoreboard;
        logic [COEF_W-1:0] coef [COEF_N];
        hpm_out_t          pending [$];
        int                errors;

        function new();
            for (int i = 0; i < COEF_N; i++)
                coef[i] = COEF_RESET[i];
            errors = 0;
        endfunction

        function void write_coef(int idx, logic [COEF_W-1:0] val);
            if (idx < COEF_N)
                coef[idx] = val;
        endfunction

        function void report(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endfunction

        // Rounded, saturated |num|*2^16/|den| with sign; num Q.20, den Q.32
        function logic [COORD_W-1:0] quotient_q12_4(longint num, longint den);
            logic [79:0] n, d, q, r;
            logic        neg;
            n   = 80'(num < 0 ? -num : num) << 16;
            d   = 80'(den < 0 ? -den : den);
            q   = n / d;
            r   = n % d;
            neg = (num < 0) != (den < 0);
            if (r >= d - r)
                q++;
            if (q == 0)
                return '0;
            if (neg)
                return (q >= 32768) ? Q_NEG_MIN : COORD_W'(-q);
            return (q > 32767) ? Q_POS_MAX : COORD_W'(q);
        endfunction

        function void note_input(hpm_in_t p);
            longint   x, y, u, v, s;
            hpm_out_t r;
            x = longint'(p.src_x);
            y = longint'(p.src_y);
            u = longint'($signed(coef[REG_COEF_A])) * x
              + longint'($signed(coef[REG_COEF_B])) * y
              + longint'($signed(coef[REG_COEF_C])) * 16;
            v = longint'($signed(coef[REG_COEF_D])) * x
              + longint'($signed(coef[REG_COEF_E])) * y
              + longint'($signed(coef[REG_COEF_F])) * 16;
            s = longint'($signed(coef[REG_COEF_G])) * x
              + longint'($signed(coef[REG_COEF_H])) * y
              + (longint'(1) << 32);
            if (s == 0)
            begin
                r.dst_x       = INVALID_COORD;
                r.dst_y       = INVALID_COORD;
                r.point_valid = 1'b0;
            end
            else
            begin
                r.dst_x       = quotient_q12_4(u, s);
                r.dst_y       = quotient_q12_4(v, s);
                r.point_valid = 1'b1;
            end
            pending = {pending, r};
        endfunction

        function void check_result(hpm_out_t got);
            hpm_out_t exp_pt;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected output %h", got));
                return;
            end
            exp_pt = pending.pop_front();
            if (got.dst_x !== exp_pt.dst_x)
                report($sformatf("dst_x %h, expected %h", got.dst_x, exp_pt.dst_x));
            if (got.dst_y !== exp_pt.dst_y)
                report($sformatf("dst_y %h, expected %h", got.dst_y, exp_pt.dst_y));
            if (got.point_valid !== exp_pt.point_valid)
                report($sformatf("point_valid %b, expected %b",
                                 got.point_valid, exp_pt.point_valid));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [COEF_W-1:0]     cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    hpm_in_t               in_data;
    logic                  out_valid;
    logic                  out_stall;
    hpm_out_t              out_data;

    point_scoreboard sb;
    bit              quiet;
    int              idle_cnt;

    homography_point_mapper_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Output side: check every transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    // Output side: stall in random bursts, none in the quiet tail
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            idle_cnt <= 0;
        else if (idle_cnt >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cnt <= idle_cnt + 1;
    end

    // Single register write; the caller lowers cfg_we after a batch
    task automatic write_reg(int idx, logic [COEF_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_ADDR_W'(idx);
        cfg_wdata <= val;
        sb.write_coef(idx, val);
        @(posedge clk);
    endtask

    task automatic load_coefs(logic [COEF_W-1:0] c [COEF_N]);
        for (int i = 0; i < COEF_N; i++)
            write_reg(i, c[i]);
        // index past the last coefficient must be ignored
        if ($urandom_range(0, 1))
            write_reg($urandom_range(2**CFG_ADDR_W - 1, COEF_N), $urandom);
        cfg_we <= 1'b0;
    endtask

    // Send one point, holding it until the transfer, optional gap first
    task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        hpm_in_t p;
        p.src_x = x;
        p.src_y = y;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        sb.note_input(p);
    endtask

    // Wait for all expected points, then let the pipeline empty
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return COORD_W'($urandom);
            1:       return COORD_W'($urandom_range(0, 8191)) - 16'd4096;
            2:       return COORD_W'($urandom_range(0, 255)) - 16'd128;
            default: return COORD_W'($urandom_range(0, 63)) << 4;
        endcase
    endfunction

    initial
    begin
        logic [COEF_W-1:0]  c [COEF_N];
        logic [COORD_W-1:0] x, y;
        int                 k;

        sb        = new();
        quiet     = 1'b0;
        idle_cnt  = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity after reset: coordinate extremes pass straight through
        send_point(16'h8000, 16'h7FFF);
        send_point(16'h7FFF, 16'h8000);
        send_point(16'h0000, 16'h0000);
        send_point(16'hFFFF, 16'h0001);
        send_point(16'h0010, 16'hFFF0);
        send_point(16'h1234, 16'hEDCB);
        drain();

        // Largest coefficients: saturation both ways
        foreach (c[i]) c[i] = 32'h7FFF_FFFF;
        load_coefs(c);
        send_point(16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000);
        send_point(16'h0001, 16'hFFFF);
        drain();
        foreach (c[i]) c[i] = 32'h8000_0000;
        load_coefs(c);
        send_point(16'h7FFF, 16'h8000);
        send_point(16'h8000, 16'h0000);
        send_point(16'hFFFF, 16'h0001);
        drain();

        // Perspective row -1.0 in x: s is zero at x = 1.0
        c = '{32'h0001_0000, 32'h0000_4000, 32'h0002_0000, 32'hFFFF_0000,
              32'h0001_8000, 32'hFFFE_0000, 32'hF000_0000, 32'h0123_4567};
        load_coefs(c);
        send_point(16'h0010, 16'h0000);
        send_point(16'h0010, 16'h0001);
        send_point(16'h0008, 16'h0000);
        send_point(16'h0020, 16'h0000);
        send_point(16'hFFF0, 16'h0000);
        send_point(16'h0018, 16'h7FFF);
        drain();

        // Random phases; the last one runs without idling
        for (int ph = 0; ph < 9; ph++)
        begin
            k = $urandom_range(1, 15);
            case (ph % 3)
                0:
                    foreach (c[i]) c[i] = $urandom;
                1:
                begin
                    // near-affine with a mild perspective
                    c[REG_COEF_A] = 32'h0001_0000 + $urandom_range(0, 65535) - 32768;
                    c[REG_COEF_B] = $urandom_range(0, 65535) - 32768;
                    c[REG_COEF_C] = $urandom_range(0, 2**24) - 2**23;
                    c[REG_COEF_D] = $urandom_range(0, 65535) - 32768;
                    c[REG_COEF_E] = 32'h0001_0000 + $urandom_range(0, 65535) - 32768;
                    c[REG_COEF_F] = $urandom_range(0, 2**24) - 2**23;
                    c[REG_COEF_G] = $urandom_range(0, 2**20) - 2**19;
                    c[REG_COEF_H] = $urandom_range(0, 2**20) - 2**19;
                end
                default:
                begin
                    // singular: s is zero at x = 2^k with y = 0
                    foreach (c[i]) c[i] = $urandom;
                    c[REG_COEF_G] = -(32'h1 << (32 - k));
                end
            endcase
            if (ph == 8)
                quiet = 1'b1;
            load_coefs(c);
            for (int n = 0; n < 200; n++)
            begin
                x = rand_coord();
                y = rand_coord();
                if (ph % 3 == 2 && $urandom_range(0, 4) == 0)
                begin
                    x = COORD_W'(1) << k;
                    y = '0;
                end
                send_point(x, y);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
